// File: sv/decimating_fir_correlator_bank_peaks_top_assert.svh
// Assertion macros shared by the RTL of the decimating FIR correlator bank.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DECIMATING_FIR_CORRELATOR_BANK_PEAKS_TOP_ASSERT_SVH
`define DECIMATING_FIR_CORRELATOR_BANK_PEAKS_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define DFCBP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define DFCBP_NEVER(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// File: sv/dfcbp_pkg.sv
// Shared types and constants of the decimating FIR correlator bank.
// No dependencies.
`default_nettype none

package dfcbp_pkg;

    localparam int TAPS_PER_PHASE_DEF = 16;
    localparam int CODE_TAPS_DEF      = 32;
    localparam int CODES_DEF          = 8;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int COEF_BITS = 16;
    localparam int PEAK_BITS = 36;
    localparam int SHIFT_BITS = 5;

    // Tag that travels with each product through the multiply-accumulate.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic pass_end;
    } mac_tag_t;

endpackage

`default_nettype wire

// File: sv/dfcbp_mac.sv
// Pipelined multiply-accumulate shared by the FIR and correlator passes.
// Depends on dfcbp_pkg.
`default_nettype none

module dfcbp_mac #(
    parameter int SAMPLE_BITS = dfcbp_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_W       = 40
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  dfcbp_pkg::mac_tag_t              in_tag,
    input  wire signed [dfcbp_pkg::COEF_BITS-1:0] in_coef,
    input  wire signed [SAMPLE_BITS-1:0]     in_data,
    output dfcbp_pkg::mac_tag_t              out_tag,
    output logic signed [ACC_W-1:0]          out_acc
);

    localparam int PROD_W = SAMPLE_BITS + dfcbp_pkg::COEF_BITS;

    dfcbp_pkg::mac_tag_t       prod_tag_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    dfcbp_pkg::mac_tag_t       out_tag_reg;
    logic signed [ACC_W-1:0]   out_acc_reg;

    // Restart the sum on the first product of a run.
    always_comb begin
        if (prod_tag_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_tag_reg <= '0;
            out_tag_reg  <= '0;
        end else begin
            prod_tag_reg <= in_tag;
            out_tag_reg.vld      <= prod_tag_reg.vld && prod_tag_reg.last;
            out_tag_reg.first    <= 1'b0;
            out_tag_reg.last     <= prod_tag_reg.last;
            out_tag_reg.pass_end <= prod_tag_reg.pass_end;
        end
        prod_reg <= in_coef * in_data;
        if (prod_tag_reg.vld) begin
            acc_reg <= acc_next;
        end
        if (prod_tag_reg.vld && prod_tag_reg.last) begin
            out_acc_reg <= acc_next;
        end
    end

    assign out_tag = out_tag_reg;
    assign out_acc = out_acc_reg;

endmodule

`default_nettype wire

// File: sv/decimating_fir_correlator_bank_peaks_top.sv
// Top level of the decimate-by-2 polyphase FIR and matched correlator bank.
// Depends on dfcbp_pkg, dfcbp_mac and the assertion macro header.
//
// Usage:
//   Input beats (s_) carry one item: s_tuser gives the mode, where mode 0
//   is a sample, mode 1 loads a filter tap and mode 2 loads a code-table
//   word; s_tlast marks frame end.
//   Loads and odd-indexed samples are only stored. An even-indexed sample
//   runs one FIR pass over the tap memory (2*TAPS_PER_PHASE products plus a
//   drain through the issue, product and output registers) and one
//   correlation pass over the code memory (CODES*CODE_TAPS products plus the
//   drain). The single multiplier and the one read port of each memory
//   serialise these passes; s_tready is high only between items.
//   On a frame-end sample the block sends CODES result beats (m_), one
//   per code in order, m_tlast on the last one, then clears the delay
//   lines, the peaks and the sample phase. Results sit in an output
//   register; while m_tready is low the block holds the current beat and
//   stops advancing the peak rotation.
//   Reset clears all frame state and sets filter_shift to 15; the tap and
//   code memories keep no reset value and must be loaded before use.
//   User must write filter_shift via cfg_wr_en only while idle (unchecked).
`default_nettype none

module decimating_fir_correlator_bank_peaks_top #(
    parameter int TAPS_PER_PHASE = dfcbp_pkg::TAPS_PER_PHASE_DEF,
    parameter int CODE_TAPS      = dfcbp_pkg::CODE_TAPS_DEF,
    parameter int CODES          = dfcbp_pkg::CODES_DEF,
    parameter int SAMPLE_BITS    = dfcbp_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W  = ((SAMPLE_BITS + 8 + dfcbp_pkg::COEF_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((dfcbp_pkg::PEAK_BITS + 7) / 8) * 8,
    localparam int CW    = (CODES > 1) ? $clog2(CODES) : 1
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_wr_en,
    input  wire [dfcbp_pkg::SHIFT_BITS-1:0] cfg_wr_data,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // sample, tap_index[4:0], code_select[2:0], coef_value[15:0]
    input  wire [IN_W-1:0]        s_tdata,
    // mode[1:0]
    input  wire [1:0]             s_tuser,
    input  wire                   s_tlast,   // frame_end
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // peak_value[35:0]
    output logic [OUT_W-1:0]      m_tdata,
    // code_index
    output logic [CW-1:0]         m_tuser,
    output logic                  m_tlast    // last_of_run
);

    localparam int SB     = SAMPLE_BITS;
    localparam int TAP_N  = 2 * TAPS_PER_PHASE;
    localparam int TAW    = $clog2(TAP_N);
    localparam int CODE_N = CODES * CODE_TAPS;
    localparam int CAW    = (CODE_N > 1) ? $clog2(CODE_N) : 1;
    localparam int KMAX   = (TAP_N > CODE_TAPS) ? TAP_N : CODE_TAPS;
    localparam int KW     = $clog2(KMAX);
    localparam int TW     = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;
    localparam int CKW    = (CODE_TAPS > 1) ? $clog2(CODE_TAPS) : 1;
    localparam int PB     = dfcbp_pkg::PEAK_BITS;
    localparam int CB     = dfcbp_pkg::COEF_BITS;
    localparam int ACC_W  = SB + CB + KW + 1;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_TAP    = 2'd1;
    localparam logic [1:0] MODE_CODE   = 2'd2;

    localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] Y_LO = -Y_HI - ACC_W'(1);
    localparam logic signed [63:0] PEAK_MAX = (64'sd1 <<< PB) - 64'sd1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FIR_RUN, ST_CORR_RUN, ST_DRAIN, ST_EMIT
    } state_t;

    // Field unpacking.
    logic [1:0]           in_mode;
    logic signed [SB-1:0] in_sample;
    logic [4:0]           in_tap;
    logic [2:0]           in_sel;
    logic signed [CB-1:0] in_coef;

    assign in_mode   = s_tuser;
    assign in_sample = s_tdata[SB-1:0];
    assign in_tap    = s_tdata[SB+4:SB];
    assign in_sel    = s_tdata[SB+7:SB+5];
    assign in_coef   = s_tdata[SB+CB+7:SB+8];

    state_t                      state_reg;
    logic                        pass_corr_reg;
    logic                        fe_reg;
    logic                        phase_reg;
    logic signed [SB-1:0]        held_reg;
    logic [dfcbp_pkg::SHIFT_BITS-1:0] shift_reg;
    logic [KW-1:0]               cnt_reg;
    logic [CW-1:0]               c_reg;
    logic [CAW-1:0]              addr_reg;
    logic [CW-1:0]               e_reg;

    logic signed [SB-1:0] even_dly_reg [TAPS_PER_PHASE];
    logic signed [SB-1:0] odd_dly_reg  [TAPS_PER_PHASE];
    logic signed [SB-1:0] code_dly_reg [CODE_TAPS];
    logic [PB-1:0]        peak_reg [CODES];

    logic                 m_tvalid_reg;
    logic [PB-1:0]        m_peak_reg;
    logic [CW-1:0]        m_code_reg;
    logic                 m_last_reg;

    // Coefficient memories, one synchronous read port each.
    logic signed [CB-1:0] tap_mem  [TAP_N];
    logic signed [CB-1:0] code_mem [CODE_N];
    logic signed [CB-1:0] tap_q_reg;
    logic signed [CB-1:0] code_q_reg;

    logic accept;
    logic tap_we;
    logic code_we;
    logic issuing;
    logic emit_load;

    assign accept  = s_tvalid && s_tready;
    assign tap_we  = accept && (in_mode == MODE_TAP) && (32'(in_tap) < TAP_N);
    assign code_we = accept && (in_mode == MODE_CODE) && (32'(in_tap) < CODE_TAPS)
                     && (32'(in_sel) < CODES);
    assign issuing = (state_reg == ST_FIR_RUN) || (state_reg == ST_CORR_RUN);
    // Load the next result beat once the output register is free.
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (tap_we) begin
            tap_mem[TAW'(in_tap)] <= in_coef;
        end
        if (code_we) begin
            code_mem[CAW'(32'(in_sel) * CODE_TAPS + 32'(in_tap))] <= in_coef;
        end
        tap_q_reg  <= tap_mem[cnt_reg[TAW-1:0]];
        code_q_reg <= code_mem[addr_reg];
    end

    // Issue stage: pick the delay-line operand alongside the memory read.
    logic signed [SB-1:0] fir_dly;
    logic signed [SB-1:0] corr_dly;
    logic                 run_last;
    logic                 run_end;
    dfcbp_pkg::mac_tag_t  tag1_reg;
    logic signed [SB-1:0] d1_reg;

    always_comb begin
        if (cnt_reg[0]) begin
            fir_dly = odd_dly_reg[TW'(cnt_reg >> 1)];
        end else begin
            fir_dly = even_dly_reg[TW'(cnt_reg >> 1)];
        end
        corr_dly = code_dly_reg[CKW'(CODE_TAPS - 1) - CKW'(cnt_reg)];
        if (pass_corr_reg) begin
            run_last = (cnt_reg == KW'(CODE_TAPS - 1));
            run_end  = run_last && (c_reg == CW'(CODES - 1));
        end else begin
            run_last = (cnt_reg == KW'(TAP_N - 1));
            run_end  = run_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
        end else begin
            tag1_reg.vld      <= issuing;
            tag1_reg.first    <= (cnt_reg == '0);
            tag1_reg.last     <= run_last;
            tag1_reg.pass_end <= run_end;
        end
        d1_reg <= pass_corr_reg ? corr_dly : fir_dly;
    end

    dfcbp_pkg::mac_tag_t     fin_tag;
    logic signed [ACC_W-1:0] fin_acc;

    dfcbp_mac #(
        .SAMPLE_BITS(SB),
        .ACC_W      (ACC_W)
    ) u_mac (
        .aclk   (aclk),
        .aresetn(aresetn),
        .in_tag (tag1_reg),
        .in_coef(pass_corr_reg ? code_q_reg : tap_q_reg),
        .in_data(d1_reg),
        .out_tag(fin_tag),
        .out_acc(fin_acc)
    );

    // Filter output: floor shift, then saturate to the sample range.
    logic signed [ACC_W-1:0] fir_shifted;
    logic signed [SB-1:0]    fir_y;
    logic signed [63:0]      acc64;
    logic [PB-1:0]           corr_clip;
    logic [PB-1:0]           peak_next;

    always_comb begin
        fir_shifted = fin_acc >>> shift_reg;
        if (fir_shifted > Y_HI) begin
            fir_y = SB'(Y_HI);
        end else if (fir_shifted < Y_LO) begin
            fir_y = SB'(Y_LO);
        end else begin
            fir_y = SB'(fir_shifted);
        end
        acc64     = 64'(fin_acc);
        corr_clip = (acc64 > PEAK_MAX) ? PB'(PEAK_MAX) : PB'(acc64);
        peak_next = (acc64 > $signed({28'd0, peak_reg[0]})) ? corr_clip : peak_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pass_corr_reg <= 1'b0;
            fe_reg        <= 1'b0;
            phase_reg     <= 1'b0;
            held_reg      <= '0;
            shift_reg     <= dfcbp_pkg::SHIFT_BITS'(15);
            cnt_reg       <= '0;
            c_reg         <= '0;
            addr_reg      <= '0;
            e_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < TAPS_PER_PHASE; i++) begin
                even_dly_reg[i] <= '0;
                odd_dly_reg[i]  <= '0;
            end
            for (int k = 0; k < CODE_TAPS; k++) begin
                code_dly_reg[k] <= '0;
            end
            for (int c = 0; c < CODES; c++) begin
                peak_reg[c] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                shift_reg <= cfg_wr_data;
            end
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // Peaks rotate once per code, so code 0 always sits at the head.
            if (fin_tag.vld && pass_corr_reg) begin
                for (int c = 0; c < CODES - 1; c++) begin
                    peak_reg[c] <= peak_reg[c+1];
                end
                peak_reg[CODES-1] <= peak_next;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (in_mode == MODE_SAMPLE)) begin
                        fe_reg <= s_tlast;
                        e_reg  <= '0;
                        if (phase_reg) begin
                            held_reg  <= in_sample;
                            phase_reg <= 1'b0;
                            if (s_tlast) begin
                                state_reg <= ST_EMIT;
                            end
                        end else begin
                            for (int i = TAPS_PER_PHASE - 1; i > 0; i--) begin
                                even_dly_reg[i] <= even_dly_reg[i-1];
                                odd_dly_reg[i]  <= odd_dly_reg[i-1];
                            end
                            even_dly_reg[0] <= in_sample;
                            odd_dly_reg[0]  <= held_reg;
                            phase_reg       <= 1'b1;
                            pass_corr_reg   <= 1'b0;
                            cnt_reg         <= '0;
                            state_reg       <= ST_FIR_RUN;
                        end
                    end
                end
                ST_FIR_RUN: begin
                    cnt_reg <= cnt_reg + KW'(1);
                    if (run_end) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_CORR_RUN: begin
                    addr_reg <= addr_reg + CAW'(1);
                    if (run_last) begin
                        cnt_reg <= '0;
                        c_reg   <= c_reg + CW'(1);
                    end else begin
                        cnt_reg <= cnt_reg + KW'(1);
                    end
                    if (run_end) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (fin_tag.vld && fin_tag.pass_end) begin
                        if (!pass_corr_reg) begin
                            for (int k = CODE_TAPS - 1; k > 0; k--) begin
                                code_dly_reg[k] <= code_dly_reg[k-1];
                            end
                            code_dly_reg[0] <= fir_y;
                            pass_corr_reg   <= 1'b1;
                            cnt_reg         <= '0;
                            c_reg           <= '0;
                            addr_reg        <= '0;
                            state_reg       <= ST_CORR_RUN;
                        end else begin
                            state_reg <= fe_reg ? ST_EMIT : ST_IDLE;
                        end
                    end
                end
                ST_EMIT: begin
                    // Zeros rotate in behind, which clears the peaks.
                    if (emit_load) begin
                        m_peak_reg <= peak_reg[0];
                        m_code_reg <= e_reg;
                        m_last_reg <= (e_reg == CW'(CODES - 1));
                        for (int c = 0; c < CODES - 1; c++) begin
                            peak_reg[c] <= peak_reg[c+1];
                        end
                        peak_reg[CODES-1] <= '0;
                        e_reg <= e_reg + CW'(1);
                        if (e_reg == CW'(CODES - 1)) begin
                            for (int i = 0; i < TAPS_PER_PHASE; i++) begin
                                even_dly_reg[i] <= '0;
                                odd_dly_reg[i]  <= '0;
                            end
                            for (int k = 0; k < CODE_TAPS; k++) begin
                                code_dly_reg[k] <= '0;
                            end
                            held_reg  <= '0;
                            phase_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(m_peak_reg);
    assign m_tuser  = m_code_reg;
    assign m_tlast  = m_last_reg;

`include "decimating_fir_correlator_bank_peaks_top_assert.svh"

    `DFCBP_NEVER(a_idle_pipe_empty, s_tready && (tag1_reg.vld || fin_tag.vld), "pipe busy")
    `DFCBP_ASSERT(a_last_code, (m_tvalid && m_tlast) |-> m_tuser == CW'(CODES - 1), "bad tlast")
    `DFCBP_NEVER(a_issue_idle, issuing && s_tready, "issuing while accepting")
    `DFCBP_ASSERT(a_fin_drain, fin_tag.vld && fin_tag.pass_end |-> state_reg == ST_DRAIN, "no drain")

endmodule

`default_nettype wire

// File: dv/dfcbp_peak_checker.sv
// Scoreboard for the decimating FIR correlator bank: mirrors the filter and
// correlator state from the observed input and config beats, then checks each
// peak beat. Depends on dfcbp_pkg and on dfcbp_tb_pkg, which is defined below.
`default_nettype none

package dfcbp_tb_pkg;
    localparam logic [1:0] MODE_SAMPLE    = 2'd0;
    localparam logic [1:0] MODE_LOAD_TAP  = 2'd1;
    localparam logic [1:0] MODE_LOAD_CODE = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
endpackage

module dfcbp_peak_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire [dfcbp_pkg::SHIFT_BITS-1:0] cfg_wr_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [39:0]  s_tdata,
    input  wire [1:0]   s_tuser,
    input  wire         s_tlast,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [39:0]  m_tdata,
    input  wire [2:0]   m_tuser,
    input  wire         m_tlast,
    output int          errors,
    output int          pending,
    output int          peaks_seen
);

    localparam int TPP = dfcbp_pkg::TAPS_PER_PHASE_DEF;
    localparam int CTAPS = dfcbp_pkg::CODE_TAPS_DEF;
    localparam int NCODES = dfcbp_pkg::CODES_DEF;
    localparam longint PEAK_LIMIT = 64'hF_FFFF_FFFF;

    typedef struct {
        logic [2:0]  code;
        logic [35:0] peak;
        logic        last;
    } peak_beat_t;

    peak_beat_t peak_queue[$];

    logic signed [15:0] even_line [TPP];
    logic signed [15:0] odd_line [TPP];
    logic signed [15:0] held_odd;
    logic               odd_next;
    logic signed [15:0] decim_line [CTAPS];
    longint             peak_run [NCODES];
    logic signed [15:0] tap_mem [2*TPP];
    logic signed [15:0] code_mem [NCODES*CTAPS];
    logic [4:0]         shift_q;

    initial begin
        errors = 0;
        pending = 0;
        peaks_seen = 0;
    end

    task automatic clear_frame();
        for (int i = 0; i < TPP; i++) begin
            even_line[i] = '0;
            odd_line[i] = '0;
        end
        for (int k = 0; k < CTAPS; k++) decim_line[k] = '0;
        for (int c = 0; c < NCODES; c++) peak_run[c] = 0;
        held_odd = '0;
        odd_next = 1'b0;
    endtask

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Run one decimated filter output through the correlators.
    task automatic filter_and_correlate(input logic signed [15:0] smp);
        longint sum;
        longint y;
        longint acc;
        sum = 0;
        for (int i = TPP - 1; i > 0; i--) begin
            even_line[i] = even_line[i-1];
            odd_line[i] = odd_line[i-1];
        end
        even_line[0] = smp;
        odd_line[0] = held_odd;
        for (int i = 0; i < TPP; i++)
            sum += longint'(even_line[i]) * longint'(tap_mem[2*i])
                 + longint'(odd_line[i]) * longint'(tap_mem[2*i+1]);
        y = sum >>> shift_q;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        for (int k = CTAPS - 1; k > 0; k--) decim_line[k] = decim_line[k-1];
        decim_line[0] = 16'(y);
        for (int c = 0; c < NCODES; c++) begin
            acc = 0;
            for (int k = 0; k < CTAPS; k++)
                acc += longint'(decim_line[CTAPS-1-k]) * longint'(code_mem[c*CTAPS+k]);
            if (acc > PEAK_LIMIT) acc = PEAK_LIMIT;
            if (acc > peak_run[c]) peak_run[c] = acc;
        end
    endtask

    task automatic absorb_beat(input logic [1:0] mode, input logic [39:0] d,
                               input logic fe);
        logic signed [15:0] smp;
        logic [4:0] tap;
        logic [2:0] sel;
        peak_beat_t pb;
        smp = d[15:0];
        tap = d[20:16];
        sel = d[23:21];
        case (mode)
            dfcbp_tb_pkg::MODE_LOAD_TAP: tap_mem[tap] = d[39:24];
            dfcbp_tb_pkg::MODE_LOAD_CODE: code_mem[sel*CTAPS + tap] = d[39:24];
            dfcbp_tb_pkg::MODE_SAMPLE: begin
                if (odd_next) begin
                    held_odd = smp;
                    odd_next = 1'b0;
                end else begin
                    filter_and_correlate(smp);
                    odd_next = 1'b1;
                end
                if (fe) begin
                    for (int c = 0; c < NCODES; c++) begin
                        pb.code = 3'(c);
                        pb.peak = peak_run[c][35:0];
                        pb.last = (c == NCODES - 1);
                        peak_queue.push_back(pb);
                    end
                    clear_frame();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        peak_beat_t want;
        if (!aresetn) begin
            shift_q = 5'd15;
            clear_frame();
        end else begin
            if (cfg_wr_en) shift_q = cfg_wr_data;
            if (s_tvalid && s_tready) absorb_beat(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                peaks_seen++;
                if (peak_queue.size() == 0) begin
                    report($sformatf("unexpected peak beat code %0d", m_tuser));
                end else begin
                    want = peak_queue.pop_front();
                    if (m_tuser !== want.code)
                        report($sformatf("code %0d, want %0d", m_tuser, want.code));
                    if (m_tdata[35:0] !== want.peak)
                        report($sformatf("code %0d peak %0d, want %0d",
                                         want.code, m_tdata[35:0], want.peak));
                    if (m_tlast !== want.last)
                        report($sformatf("code %0d tlast %b, want %b",
                                         want.code, m_tlast, want.last));
                end
            end
        end
        pending = peak_queue.size();
    end

    final begin
        if (peak_queue.size() != 0)
            $display("%0d peak beats never arrived", peak_queue.size());
    end
endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench top for the decimating FIR correlator bank: loads the tap and code
// memories, sends sample frames and config writes, judges the run.
// Depends on dfcbp_pkg, dfcbp_tb_pkg, dfcbp_peak_checker and the block's RTL.
`default_nettype none

module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;

    int errors, pending, peaks_seen;
    int burst_left = 4;
    int frames_sent = 0;
    int cycle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    decimating_fir_correlator_bank_peaks_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    dfcbp_peak_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .errors(errors), .pending(pending), .peaks_seen(peaks_seen)
    );

    // Receiver backpressure: rotate through always-ready, random and a fixed
    // stall pattern so stalls land on every beat of a peak run.
    always @(negedge aclk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 900) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((cycle_count % 7) < 3);
        endcase
    end

    // Drive one beat and hold it until accepted; close the burst with a gap.
    task automatic send_beat(input logic [1:0] mode, input logic [15:0] smp,
                             input logic fe, input logic [4:0] tap,
                             input logic [2:0] sel, input logic [15:0] coef);
        s_tvalid <= 1'b1;
        s_tdata <= {coef, sel, tap, smp};
        s_tuser <= mode;
        s_tlast <= fe;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            // Some bursts run long so there are stretches without sender gaps.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
        end
    endtask

    task automatic send_sample(input logic [15:0] smp, input logic fe);
        send_beat(dfcbp_tb_pkg::MODE_SAMPLE, smp, fe, 5'($urandom), 3'($urandom),
                  16'($urandom));
        if (fe) frames_sent++;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Write filter_shift only once the block has drained all peaks and
    // finished any last correlation pass.
    task automatic write_shift(input logic [4:0] val);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (400) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_frames(input int beats);
        int len;
        int left;
        left = beats;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0: send_beat(dfcbp_tb_pkg::MODE_LOAD_TAP, 16'($urandom), 1'($urandom),
                             5'($urandom), 3'($urandom), 16'($urandom));
                1: send_beat(dfcbp_tb_pkg::MODE_LOAD_CODE, 16'($urandom), 1'($urandom),
                             5'($urandom), 3'($urandom), 16'($urandom));
                2: send_beat(dfcbp_tb_pkg::MODE_UNUSED, 16'($urandom), 1'($urandom),
                             5'($urandom), 3'($urandom), 16'($urandom));
                default: begin
                    // Well-formed frame with random length and contents.
                    len = $urandom_range(1, 12);
                    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
                    left -= len - 1;
                end
            endcase
            left--;
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill both memories before any sample can read them.
        for (int t = 0; t < 32; t++)
            send_beat(dfcbp_tb_pkg::MODE_LOAD_TAP, 16'($urandom), 1'b0, 5'(t),
                      3'($urandom), 16'($urandom));
        for (int c = 0; c < 8; c++)
            for (int k = 0; k < 32; k++)
                send_beat(dfcbp_tb_pkg::MODE_LOAD_CODE, 16'($urandom), 1'b0, 5'(k), 3'(c),
                          (k % 5 == 0) ? 16'h7FFF : 16'($urandom));

        // Directed: sample extremes, frame end on even and on odd samples,
        // tlast on a load, the unused mode, coefficient extremes.
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_beat(dfcbp_tb_pkg::MODE_LOAD_TAP, 16'h0, 1'b1, 5'd0, 3'd0, 16'h8000);
        send_beat(dfcbp_tb_pkg::MODE_LOAD_TAP, 16'h0, 1'b0, 5'd31, 3'd7, 16'h7FFF);
        send_beat(dfcbp_tb_pkg::MODE_LOAD_CODE, 16'h0, 1'b1, 5'd31, 3'd7, 16'h8000);
        send_beat(dfcbp_tb_pkg::MODE_UNUSED, 16'hFFFF, 1'b1, 5'd31, 3'd7, 16'hFFFF);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        for (int i = 0; i < 6; i++) send_sample(16'h7FFF, i == 5);

        // Phases at the reset shift, the extremes and a random shift.
        random_frames(14);
        write_shift(5'd0);
        for (int i = 0; i < 4; i++) send_sample(16'h7FFF, i == 3);
        random_frames(12);
        write_shift(5'd31);
        random_frames(12);
        write_shift(5'($urandom_range(8, 20)));
        random_frames(14);

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (400) @(posedge aclk);
        $display("Sent %0d frames across four shift settings; checked %0d peak beats.",
                 frames_sent, peaks_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("Timed out waiting for the block");
        $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
